// File: design/mpzd_pkg.sv
package mpzd_pkg;

  // Default sample width of the ADC front end.
  localparam int SAMPLE_BITS_DEF = 12;

  // Configuration register widths.
  localparam int CLAMP_BITS   = 13;
  localparam int MINSPAN_BITS = 12;

  // APB register map: byte address 4*i, decoded on paddr[3:2].
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_CLAMP_LOW  = 2'd0,
    REG_CLAMP_HIGH = 2'd1,
    REG_MIN_SPAN   = 2'd2
  } reg_idx_t;

  localparam logic [CLAMP_BITS-1:0]   CLAMP_OFF     = '1;
  localparam logic [MINSPAN_BITS-1:0] MIN_SPAN_RST  = 12'd256;

  // Threshold scale factors: high above 0.67 of the span, low below 0.33.
  localparam int SCALE_ONE  = 100;
  localparam int SCALE_HIGH = 67;
  localparam int SCALE_LOW  = 33;

  typedef enum logic [2:0] {
    ZONE_SEEDED      = 3'd0,
    ZONE_WAIT        = 3'd1,
    ZONE_LOW         = 3'd2,
    ZONE_HIGH        = 3'd3,
    ZONE_ENTER_LOW   = 3'd4,
    ZONE_ENTER_HIGH  = 3'd5,
    ZONE_MIDDLE      = 3'd6
  } zone_t;

endpackage

// File: design/magnet_pole_zone_detector.sv
// Path: an accepted input beat goes into the stage 1 register, then into the result register.
// Throughput: 1 beat per cycle while out_stall is low; the peak/span update and zone compare
// are combinational between the input and result registers, so state feedback sets the rate.
// Reset (rst, synchronous, active high): not seeded, peaks and span 0, both zone flags armed,
// clamps off (-1), min_span 256, both pipeline stages empty.
module magnet_pole_zone_detector
  import mpzd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // sample channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             zone_code,
  output logic [SAMPLE_BITS-1:0] clamped_sample,
  // APB configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]   prdata,
  output logic                   pready
);

  // Compare width: 100*x and 67*span + 100*low_peak need SAMPLE_BITS+9 signed bits;
  // one more bit of margin.
  localparam int SB = SAMPLE_BITS;
  localparam int CW = SAMPLE_BITS + 10;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CLAMP_BITS-1:0]   clamp_low;
  logic [CLAMP_BITS-1:0]   clamp_high;
  logic [MINSPAN_BITS-1:0] min_span;
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_low  <= CLAMP_OFF;
      clamp_high <= CLAMP_OFF;
      min_span   <= MIN_SPAN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CLAMP_LOW:  clamp_low  <= pwdata[CLAMP_BITS-1:0];
        REG_CLAMP_HIGH: clamp_high <= pwdata[CLAMP_BITS-1:0];
        REG_MIN_SPAN:   min_span   <= pwdata[MINSPAN_BITS-1:0];
        default: ;      // unmapped address, write dropped
      endcase
    end
  end

  // Clamp registers read back sign-extended.
  always_comb begin
    case (cfg_idx)
      REG_CLAMP_LOW:
        prdata = {{(DATA_BITS-CLAMP_BITS){clamp_low[CLAMP_BITS-1]}}, clamp_low};
      REG_CLAMP_HIGH:
        prdata = {{(DATA_BITS-CLAMP_BITS){clamp_high[CLAMP_BITS-1]}}, clamp_high};
      REG_MIN_SPAN:
        prdata = {{(DATA_BITS-MINSPAN_BITS){1'b0}}, min_span};
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // Stage 1 holds the raw sample; it moves into the result register whenever
  // that register is empty or its beat is being taken, so a finished result
  // never blocks the next input beat for more than the downstream stall.
  // ---------------------------------------------------------------------------
  logic          s1_valid;
  logic [SB-1:0] s1_sample;
  logic          s1_adv;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Clamp: optional lower and upper limits (all ones = off), then saturate to
  // the sample range. Done in a wide signed domain so a negative upper limit
  // drives the result to zero.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] raw_w, cl_w, ch_w, smax_w, lim_a, lim_b, lim_c;
  logic [SB-1:0]        x;

  always_comb begin
    raw_w  = $signed({{(CW-SB){1'b0}}, s1_sample});
    cl_w   = $signed({{(CW-CLAMP_BITS){clamp_low[CLAMP_BITS-1]}}, clamp_low});
    ch_w   = $signed({{(CW-CLAMP_BITS){clamp_high[CLAMP_BITS-1]}}, clamp_high});
    smax_w = $signed({{(CW-SB){1'b0}}, {SB{1'b1}}});

    lim_a = raw_w;
    if (clamp_low != CLAMP_OFF && lim_a < cl_w) begin
      lim_a = cl_w;
    end
    lim_b = lim_a;
    if (clamp_high != CLAMP_OFF && lim_b > ch_w) begin
      lim_b = ch_w;
    end
    lim_c = lim_b;
    if (lim_c < $signed(CW'(0))) begin
      lim_c = '0;
    end
    if (lim_c > smax_w) begin
      lim_c = smax_w;
    end
    x = lim_c[SB-1:0];
  end

  // ---------------------------------------------------------------------------
  // Peak tracker state
  // span is kept on its own: on zone entry it takes the old peak difference
  // before the peak moves, so it does not always equal high_peak - low_peak.
  // ---------------------------------------------------------------------------
  logic                 seeded, seeded_next;
  logic [SB-1:0]        high_peak, high_peak_next;
  logic [SB-1:0]        low_peak, low_peak_next;
  logic signed [SB:0]   span, span_next;
  logic                 high_armed, high_armed_next;
  logic                 low_armed, low_armed_next;
  zone_t                code_next;

  logic signed [CW-1:0] x100, base100, span_w, thr_high, thr_low, min_span_w;
  logic                 is_high, is_low;
  logic [SB-1:0]        hp_wide, lp_wide;

  // Threshold terms: constant multiplies only.
  always_comb begin
    x100       = $signed({{(CW-SB){1'b0}}, x}) * $signed(CW'(SCALE_ONE));
    base100    = $signed({{(CW-SB){1'b0}}, low_peak}) * $signed(CW'(SCALE_ONE));
    span_w     = $signed({{(CW-SB-1){span[SB]}}, span});
    thr_high   = span_w * $signed(CW'(SCALE_HIGH)) + base100;
    thr_low    = span_w * $signed(CW'(SCALE_LOW)) + base100;
    min_span_w = $signed({{(CW-MINSPAN_BITS){1'b0}}, min_span});
    is_high    = x100 > thr_high;
    is_low     = x100 < thr_low;
  end

  always_comb begin
    seeded_next     = seeded;
    high_peak_next  = high_peak;
    low_peak_next   = low_peak;
    span_next       = span;
    high_armed_next = high_armed;
    low_armed_next  = low_armed;
    code_next       = ZONE_MIDDLE;
    hp_wide         = (x > high_peak) ? x : high_peak;
    lp_wide         = (x < low_peak)  ? x : low_peak;

    if (!seeded) begin
      // first beat seeds both peaks
      seeded_next    = 1'b1;
      high_peak_next = x;
      low_peak_next  = x;
      span_next      = '0;
      code_next      = ZONE_SEEDED;
    end else if (span_w < min_span_w) begin
      // spread too small: only widen the peaks and the span
      code_next      = ZONE_WAIT;
      high_peak_next = hp_wide;
      low_peak_next  = lp_wide;
      if (x > high_peak || x < low_peak) begin
        span_next = $signed({1'b0, hp_wide}) - $signed({1'b0, lp_wide});
      end
    end else if (is_high) begin
      if (high_armed) begin
        high_armed_next = 1'b0;
        low_armed_next  = 1'b1;
        span_next       = $signed({1'b0, high_peak}) - $signed({1'b0, low_peak});
        high_peak_next  = x;
        code_next       = ZONE_ENTER_HIGH;
      end else begin
        code_next = ZONE_HIGH;
        if (x > high_peak) begin
          high_peak_next = x;
          span_next      = $signed({1'b0, x}) - $signed({1'b0, low_peak});
        end
      end
    end else if (is_low) begin
      if (low_armed) begin
        low_armed_next  = 1'b0;
        high_armed_next = 1'b1;
        span_next       = $signed({1'b0, high_peak}) - $signed({1'b0, low_peak});
        low_peak_next   = x;
        code_next       = ZONE_ENTER_LOW;
      end else begin
        code_next = ZONE_LOW;
        if (x < low_peak) begin
          low_peak_next = x;
          span_next     = $signed({1'b0, high_peak}) - $signed({1'b0, x});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded     <= 1'b0;
      high_peak  <= '0;
      low_peak   <= '0;
      span       <= '0;
      high_armed <= 1'b1;
      low_armed  <= 1'b1;
    end else if (s1_adv) begin
      seeded     <= seeded_next;
      high_peak  <= high_peak_next;
      low_peak   <= low_peak_next;
      span       <= span_next;
      high_armed <= high_armed_next;
      low_armed  <= low_armed_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  zone_t         out_code;
  logic [SB-1:0] out_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_code   <= code_next;
      out_sample <= x;
    end
  end

  assign zone_code      = out_code;
  assign clamped_sample = out_sample;

`ifndef SYNTHESIS
  // The zone flags are re-armed in pairs: at least one is always armed.
  a_one_armed: assert property (@(posedge clk) disable iff (rst)
    high_armed || low_armed)
    else $error("both zone flags disarmed");

  // The beat leaving stage 1 before seeding must come out as the seed code.
  a_seed_first: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !seeded) |=> (out_valid && zone_code == ZONE_SEEDED && seeded))
    else $error("first result after reset is not the seed beat");

  // Entering the high zone disarms high and arms low.
  a_enter_high: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && code_next == ZONE_ENTER_HIGH) |=> (!high_armed && low_armed))
    else $error("high zone entry left flags inconsistent");

  // Stage 1 never moves a beat into a full result register that is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !s1_adv)
    else $error("result register overwritten while stalled");
`endif

endmodule

// File: bench/magnet_pole_zone_detector_tb.sv
`timescale 1ns / 1ps

module magnet_pole_zone_detector_tb;
  import mpzd_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int SMAX = (1 << SW) - 1;
  localparam int PCT_ONE = 100;
  localparam int PCT_HI = 67;
  localparam int PCT_LO = 33;
  localparam int MAX_IDLE = 18;
  localparam int DRAIN_SLACK = 6;          // pipeline is 2 deep, a few spare cycles
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 63;
  localparam int LIMIT_CYCLES = 400000;

  // signed 13-bit clamp encodings used by the directed rows
  localparam logic [12:0] CLAMP_NEG5 = 13'h1FFB;
  localparam logic [12:0] CLAMP_NEG100 = 13'h1F9C;
  localparam logic [12:0] CLAMP_MOST_NEG = 13'h1000;

  typedef struct packed {
    zone_t zone;
    logic [SW-1:0] clamped;
  } zone_result_t;

  typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    reg_idx_t idx;
    logic [12:0] value;     // sample for ROW_SAMPLE, register data for ROW_WRITE
    bit typed;              // expected result spelled out in the row
    zone_t zone;
    logic [SW-1:0] clamped;
  } plan_row_t;

  localparam int PLAN_LEN = 36;

  // Directed sequence. Starts right after reset, so the first sample seeds.
  // With min_span 64: 900 seeds, 1000 widens to span 100, then 0/68/300/346
  // walk through low/high entries until the span goes negative (68 - 300),
  // and 500 drops the block back into widening.
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_WRITE,  REG_MIN_SPAN,   13'd64,         1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd900,        1'b1, ZONE_SEEDED,    12'd900},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd1000,       1'b1, ZONE_WAIT,      12'd1000},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd0,          1'b1, ZONE_ENTER_LOW, 12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd68,         1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd300,        1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd346,        1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd500,        1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd4095,       1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd0,          1'b0, ZONE_SEEDED,    12'd0},
    // both clamps active
    '{ROW_WRITE,  REG_CLAMP_LOW,  13'd200,        1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_WRITE,  REG_CLAMP_HIGH, 13'd3000,       1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd0,          1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd4095,       1'b0, ZONE_SEEDED,    12'd0},
    // negative upper clamp other than off: everything saturates to 0
    '{ROW_WRITE,  REG_CLAMP_HIGH, CLAMP_NEG5,     1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd1234,       1'b0, ZONE_SEEDED,    12'd0},
    // negative lower clamp never raises anything
    '{ROW_WRITE,  REG_CLAMP_LOW,  CLAMP_NEG100,   1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_WRITE,  REG_CLAMP_HIGH, CLAMP_OFF,      1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd7,          1'b0, ZONE_SEEDED,    12'd0},
    // lower clamp at full scale
    '{ROW_WRITE,  REG_CLAMP_LOW,  13'd4095,       1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd0,          1'b0, ZONE_SEEDED,    12'd0},
    // crossed clamps: upper one wins
    '{ROW_WRITE,  REG_CLAMP_LOW,  13'd3000,       1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_WRITE,  REG_CLAMP_HIGH, 13'd1000,       1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd2000,       1'b0, ZONE_SEEDED,    12'd0},
    // no clamps, min_span 0: classify on every beat
    '{ROW_WRITE,  REG_CLAMP_LOW,  CLAMP_OFF,      1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_WRITE,  REG_CLAMP_HIGH, CLAMP_OFF,      1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_WRITE,  REG_MIN_SPAN,   13'd0,          1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd2048,       1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd2047,       1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd1,          1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd4094,       1'b0, ZONE_SEEDED,    12'd0},
    // widest min_span, then the most negative lower clamp
    '{ROW_WRITE,  REG_MIN_SPAN,   13'd4095,       1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd0,          1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd4095,       1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_WRITE,  REG_CLAMP_LOW,  CLAMP_MOST_NEG, 1'b0, ZONE_SEEDED,    12'd0},
    '{ROW_SAMPLE, REG_CLAMP_LOW,  13'd10,         1'b0, ZONE_SEEDED,    12'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SW-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] zone_code;
  logic [SW-1:0] clamped_sample;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  // predictor copy of the registers and tracker state
  int cfg_clamp_lo = -1;
  int cfg_clamp_hi = -1;
  int cfg_min_span = 256;
  bit trk_seeded = 1'b0;
  int trk_hi = 0;
  int trk_lo = 0;
  int trk_span = 0;
  bit trk_hi_armed = 1'b1;
  bit trk_lo_armed = 1'b1;

  zone_result_t pending_zones[$];
  zone_result_t seen_exp;
  int error_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  always #4 clk = ~clk;

  magnet_pole_zone_detector dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .zone_code(zone_code),
    .clamped_sample(clamped_sample),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Clamp, then classify one sample; updates the tracker state.
  function automatic zone_result_t track_zone(input logic [SW-1:0] raw);
    int x;
    int x100;
    int base;
    zone_result_t r;
    x = raw;
    if (cfg_clamp_lo != -1 && x < cfg_clamp_lo) x = cfg_clamp_lo;
    if (cfg_clamp_hi != -1 && x > cfg_clamp_hi) x = cfg_clamp_hi;
    if (x < 0) x = 0;
    if (x > SMAX) x = SMAX;
    r.clamped = x[SW-1:0];
    x100 = x * PCT_ONE;
    base = trk_lo * PCT_ONE;
    if (!trk_seeded) begin
      trk_seeded = 1'b1;
      trk_hi = x;
      trk_lo = x;
      trk_span = 0;
      r.zone = ZONE_SEEDED;
    end else if (trk_span < cfg_min_span) begin
      // still widening: peaks only move outward
      if (trk_hi < x) begin
        trk_hi = x;
        trk_span = trk_hi - trk_lo;
      end
      if (trk_lo > x) begin
        trk_lo = x;
        trk_span = trk_hi - trk_lo;
      end
      r.zone = ZONE_WAIT;
    end else if (x100 > trk_span * PCT_HI + base) begin
      if (trk_hi_armed) begin
        // span is taken from the old peaks before the peak moves
        trk_hi_armed = 1'b0;
        trk_lo_armed = 1'b1;
        trk_span = trk_hi - trk_lo;
        trk_hi = x;
        r.zone = ZONE_ENTER_HIGH;
      end else begin
        if (x > trk_hi) begin
          trk_hi = x;
          trk_span = trk_hi - trk_lo;
        end
        r.zone = ZONE_HIGH;
      end
    end else if (x100 < trk_span * PCT_LO + base) begin
      if (trk_lo_armed) begin
        trk_lo_armed = 1'b0;
        trk_hi_armed = 1'b1;
        trk_span = trk_hi - trk_lo;
        trk_lo = x;
        r.zone = ZONE_ENTER_LOW;
      end else begin
        if (x < trk_lo) begin
          trk_lo = x;
          trk_span = trk_hi - trk_lo;
        end
        r.zone = ZONE_LOW;
      end
    end else begin
      r.zone = ZONE_MIDDLE;
    end
    return r;
  endfunction

  // One sample beat: optional idle gap, hold until accepted, then queue the
  // expected result (spelled-out value for typed rows, predictor otherwise).
  task automatic send_sample(input logic [SW-1:0] v, input bit typed,
                             input zone_result_t typed_exp);
    int gap;
    zone_result_t pred;
    gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = track_zone(v);
    pending_zones.push_back(typed ? typed_exp : pred);
  endtask

  // Stop sending and wait until every pending result beat has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_zones.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // APB write: setup then access; upper data bits carry junk the block must ignore.
  task automatic write_reg(input reg_idx_t idx, input logic [12:0] val);
    logic [DATA_BITS-1:0] word;
    logic signed [12:0] s13;
    word = $urandom;
    word[12:0] = val;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    s13 = word[12:0];
    case (idx)
      REG_CLAMP_LOW: cfg_clamp_lo = s13;
      REG_CLAMP_HIGH: cfg_clamp_hi = s13;
      REG_MIN_SPAN: cfg_min_span = word[11:0];
      default: ;
    endcase
  endtask

  // Result side: check each accepted beat against the oldest expectation,
  // then hold off for a random number of cycles after it.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_zones.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat zone_code %0d clamped_sample %0d",
                 $time, zone_code, clamped_sample);
      end else begin
        seen_exp = pending_zones.pop_front();
        if (zone_code !== seen_exp.zone) begin
          error_count++;
          $display("%0t: zone_code expected %0d actual %0d", $time, seen_exp.zone,
                   zone_code);
        end
        if (clamped_sample !== seen_exp.clamped) begin
          error_count++;
          $display("%0t: clamped_sample expected %0d actual %0d", $time,
                   seen_exp.clamped, clamped_sample);
        end
      end
      stall_left = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("magnet_pole_zone_detector_tb: done, errors");
    $finish;
  end

  initial begin
    zone_result_t typed_exp;
    int phase;
    int done_items;
    int shape;
    int seg_len;
    int lo_v;
    int hi_v;
    int per;
    int nz;
    int pos;
    int v;
    int k;
    int pick;
    logic [12:0] reg_val;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        typed_exp.zone = plan[i].zone;
        typed_exp.clamped = plan[i].clamped;
        send_sample(plan[i].value[SW-1:0], plan[i].typed, typed_exp);
      end
    end

    // random phases, each with a fresh register setting
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();

      pick = $urandom_range(0, 9);
      case (pick)
        6: reg_val = 13'($urandom_range(0, SMAX));
        7: reg_val = 13'($urandom_range(13'h1000, 13'h1FFE));   // negative, not off
        8: reg_val = 13'd0;
        9: reg_val = 13'($urandom_range(0, 800));
        default: reg_val = CLAMP_OFF;
      endcase
      write_reg(REG_CLAMP_LOW, reg_val);

      pick = $urandom_range(0, 9);
      case (pick)
        6: reg_val = 13'($urandom_range(0, SMAX));
        7: reg_val = 13'($urandom_range(13'h1000, 13'h1FFE));
        8: reg_val = 13'(SMAX);
        9: reg_val = 13'($urandom_range(3000, SMAX));
        default: reg_val = CLAMP_OFF;
      endcase
      write_reg(REG_CLAMP_HIGH, reg_val);

      // extremes of min_span in the first two phases, mostly small after that
      if (phase == 0) reg_val[11:0] = 12'd0;
      else if (phase == 1) reg_val[11:0] = 12'(SMAX);
      else if ($urandom_range(0, 3) == 0) reg_val[11:0] = 12'($urandom_range(0, SMAX));
      else reg_val[11:0] = 12'($urandom_range(0, 600));
      reg_val[12] = 1'($urandom);      // unused bit, must be ignored
      write_reg(REG_MIN_SPAN, reg_val);

      in_idle_on = ($urandom_range(0, 2) != 0);
      out_idle_on = ($urandom_range(0, 2) != 0);
      if (phase == 3) begin
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
      end

      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        // mostly triangle swings between two levels so the zones get entered
        // and re-armed; the rest is uniform noise and rail-to-rail jumps
        shape = $urandom_range(0, 7);
        seg_len = $urandom_range(8, 30);
        lo_v = $urandom_range(0, 2500);
        hi_v = $urandom_range(lo_v, SMAX);
        per = $urandom_range(2, 12);
        nz = $urandom_range(0, 40);
        for (k = 0; k < seg_len && done_items < ITEMS_PER_PHASE; k++) begin
          if (shape < 6) begin
            pos = k % (2 * per);
            if (pos > per) pos = 2 * per - pos;
            v = lo_v + (hi_v - lo_v) * pos / per + int'($urandom_range(0, 2 * nz)) - nz;
            if (v < 0) v = 0;
            if (v > SMAX) v = SMAX;
          end else if (shape == 6) begin
            v = $urandom_range(0, SMAX);
          end else begin
            v = ($urandom_range(0, 1) != 0) ? SMAX : 0;
          end
          send_sample(v[SW-1:0], 1'b0, '0);
          done_items++;
          // occasionally let the pipeline run dry mid-phase
          if ($urandom_range(0, 59) == 0) drain_results();
        end
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("magnet_pole_zone_detector_tb: done, clean");
    end else begin
      $display("magnet_pole_zone_detector_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: magnet_pole_zone_detector.f
design/mpzd_pkg.sv
design/magnet_pole_zone_detector.sv
bench/magnet_pole_zone_detector_tb.sv
